>>> hdl/klip_pkg.sv
// Shared types and constants for the keyed LRU idle pool.
package klip_pkg;

  localparam int unsigned TABLE_ENTRIES = 16;
  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned TIME_BITS = 48;
  localparam int unsigned TMO_W = 31;

  localparam logic [1:0] CFG_TOTAL_CAP    = 2'd0;
  localparam logic [1:0] CFG_PER_KEY_CAP  = 2'd1;
  localparam logic [1:0] CFG_IDLE_TIMEOUT = 2'd2;
  localparam logic [1:0] CFG_MAX_LIFETIME = 2'd3;

  localparam logic [1:0] REQ_RELEASE = 2'd0;
  localparam logic [1:0] REQ_ACQUIRE = 2'd1;
  localparam logic [1:0] REQ_REAP    = 2'd2;
  localparam logic [1:0] REQ_FLUSH   = 2'd3;

  localparam logic [1:0] KIND_HIT    = 2'd0;
  localparam logic [1:0] KIND_MISS   = 2'd1;
  localparam logic [1:0] KIND_CLOSED = 2'd2;
  localparam logic [1:0] KIND_DONE   = 2'd3;

  localparam logic [2:0] RSN_NONE     = 3'd0;
  localparam logic [2:0] RSN_KEY_CAP  = 3'd1;
  localparam logic [2:0] RSN_TOTAL    = 3'd2;
  localparam logic [2:0] RSN_IDLE     = 3'd3;
  localparam logic [2:0] RSN_LIFETIME = 3'd4;
  localparam logic [2:0] RSN_FLUSH    = 3'd5;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_ACT, S_TEST, S_JUDGE, S_NEXT
  } state_t;

  typedef enum logic [2:0] {
    PH_KEY, PH_TOT, PH_INS, PH_ACQ, PH_REAP, PH_FLUSH
  } phase_t;

  typedef struct packed {
    logic                 valid;
    logic [31:0]          key;
    logic [31:0]          handle;
    logic [TIME_BITS-1:0] stamp;
    logic [IDX_W-1:0]     rank;
  } entry_t;

  typedef struct packed {
    logic                 drop;
    logic [IDX_W-1:0]     drop_slot;
    logic [IDX_W-1:0]     drop_rank;
    logic                 ins;
    logic [IDX_W-1:0]     ins_slot;
    logic [31:0]          key;
    logic [31:0]          handle;
    logic [TIME_BITS-1:0] stamp;
  } tbl_cmd_t;

endpackage

>>> hdl/keyed_lru_idle_pool.sv
// Keyed LRU idle pool: top level with request sequencer and statistics.
// A request is taken when start is high and busy is low; busy stays high
// until the final result. Each request rescans the 16-entry table one slot
// per cycle through a single read port. Results appear for one cycle each on
// result_strobe and cannot be held off; last marks the final result.
module keyed_lru_idle_pool
  import klip_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [TMO_W-1:0]     cfg_data,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           req_type,
  input  logic [31:0]          origin_key,
  input  logic [31:0]          handle,
  input  logic [TIME_BITS-1:0] now_ms,
  output logic                 result_strobe,
  output logic [1:0]           kind,
  output logic [31:0]          out_handle,
  output logic [2:0]           close_reason,
  output logic [CNT_W-1:0]     idle_entries,
  output logic [31:0]          hit_count,
  output logic [31:0]          miss_count,
  output logic [31:0]          key_cap_evictions,
  output logic [31:0]          total_cap_evictions,
  output logic [31:0]          timeout_evictions,
  output logic [31:0]          lifetime_evictions,
  output logic                 last
);

  state_t state, state_next;
  phase_t phase, phase_next;

  logic [CNT_W-1:0] total_cap, per_key_cap;
  logic [TMO_W-1:0] idle_timeout, max_lifetime;

  logic [31:0]          req_key, req_handle;
  logic [TIME_BITS-1:0] req_now;

  logic [CNT_W-1:0] held, rem, scan_cnt;
  logic             pend;
  logic [IDX_W-1:0] pslot, tgt_rank, tgt_rank_next;

  logic [CNT_W-1:0]     match_cnt;
  logic                 kmax_found, kmin_found, tgt_found, free_found;
  logic [IDX_W-1:0]     kmax_slot, kmax_rank, kmin_slot, kmin_rank, tgt_slot, free_slot;
  logic [31:0]          kmax_handle, kmin_handle, tgt_handle;
  logic [TIME_BITS-1:0] tgt_stamp, diff;
  logic                 gt;

  entry_t   rd;
  tbl_cmd_t cmd;

  logic             go_scan, emit, emit_last, held_inc, held_dec, held_clr, rem_dec;
  logic [1:0]       emit_kind;
  logic [31:0]      emit_handle;
  logic [2:0]       emit_reason;
  logic [5:0]       stat_inc;
  logic [CNT_W-1:0] eff_cap;
  logic             idle_hit, life_hit;

  klip_table u_table (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .rd_idx  (scan_cnt[IDX_W-1:0]),
    .rd_data (rd)
  );

  assign busy = (state != S_IDLE);
  assign idle_entries = held;
  assign eff_cap = (total_cap == '0 || total_cap > CNT_W'(TABLE_ENTRIES)) ?
                   CNT_W'(TABLE_ENTRIES) : total_cap;
  assign idle_hit = (idle_timeout != '0) && gt &&
                    (diff >= TIME_BITS'(idle_timeout));
  assign life_hit = (max_lifetime != '0) && gt &&
                    (diff >= TIME_BITS'(max_lifetime));

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = (req_type == REQ_RELEASE || req_type == REQ_ACQUIRE) ?
                       S_SCAN : S_NEXT;
        end
      end
      S_SCAN: begin
        if (scan_cnt == CNT_W'(TABLE_ENTRIES)) begin
          state_next = S_ACT;
        end
      end
      S_ACT: begin
        case (phase)
          PH_KEY, PH_TOT: state_next = S_SCAN;
          PH_REAP:        state_next = S_TEST;
          PH_FLUSH:       state_next = tgt_found ? S_SCAN : S_IDLE;
          default:        state_next = S_IDLE;
        endcase
      end
      S_TEST:  state_next = S_JUDGE;
      S_JUDGE: state_next = S_NEXT;
      S_NEXT: begin
        if (phase == PH_REAP && rem == '0) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_SCAN;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    phase_next    = phase;
    tgt_rank_next = tgt_rank;
    emit          = 1'b0;
    emit_last     = 1'b0;
    emit_kind     = KIND_DONE;
    emit_handle   = '0;
    emit_reason   = RSN_NONE;
    stat_inc      = '0;
    held_inc      = 1'b0;
    held_dec      = 1'b0;
    held_clr      = 1'b0;
    rem_dec       = 1'b0;
    cmd           = '0;
    cmd.key       = req_key;
    cmd.handle    = req_handle;
    cmd.stamp     = req_now;
    case (state)
      S_IDLE: begin
        case (req_type)
          REQ_RELEASE: phase_next = PH_KEY;
          REQ_ACQUIRE: phase_next = PH_ACQ;
          REQ_REAP:    phase_next = PH_REAP;
          default:     phase_next = PH_FLUSH;
        endcase
      end
      S_ACT: begin
        case (phase)
          PH_KEY: begin
            phase_next = PH_TOT;
            if (per_key_cap != '0 && match_cnt >= per_key_cap && kmax_found) begin
              cmd.drop      = 1'b1;
              cmd.drop_slot = kmax_slot;
              cmd.drop_rank = kmax_rank;
              held_dec      = 1'b1;
              stat_inc[2]   = 1'b1;
              emit          = 1'b1;
              emit_kind     = KIND_CLOSED;
              emit_handle   = kmax_handle;
              emit_reason   = RSN_KEY_CAP;
            end
            tgt_rank_next = IDX_W'(held - CNT_W'(held_dec) - 1'b1);
          end
          PH_TOT: begin
            phase_next = PH_INS;
            if (held >= eff_cap && tgt_found) begin
              cmd.drop      = 1'b1;
              cmd.drop_slot = tgt_slot;
              cmd.drop_rank = tgt_rank;
              held_dec      = 1'b1;
              stat_inc[3]   = 1'b1;
              emit          = 1'b1;
              emit_kind     = KIND_CLOSED;
              emit_handle   = tgt_handle;
              emit_reason   = RSN_TOTAL;
            end
          end
          PH_INS: begin
            if (free_found) begin
              cmd.ins      = 1'b1;
              cmd.ins_slot = free_slot;
              held_inc     = 1'b1;
            end
            emit      = 1'b1;
            emit_last = 1'b1;
          end
          PH_ACQ: begin
            emit      = 1'b1;
            emit_last = 1'b1;
            if (kmin_found) begin
              cmd.drop      = 1'b1;
              cmd.drop_slot = kmin_slot;
              cmd.drop_rank = kmin_rank;
              held_dec      = 1'b1;
              stat_inc[0]   = 1'b1;
              emit_kind     = KIND_HIT;
              emit_handle   = kmin_handle;
            end else begin
              stat_inc[1]   = 1'b1;
              emit_kind     = KIND_MISS;
            end
          end
          PH_FLUSH: begin
            emit = 1'b1;
            if (tgt_found) begin
              cmd.drop      = 1'b1;
              cmd.drop_slot = tgt_slot;
              cmd.drop_rank = tgt_rank;
              held_dec      = 1'b1;
              emit_kind     = KIND_CLOSED;
              emit_handle   = tgt_handle;
              emit_reason   = RSN_FLUSH;
            end else begin
              held_clr  = 1'b1;
              emit_last = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      S_JUDGE: begin
        rem_dec = 1'b1;
        if (idle_hit || life_hit) begin
          cmd.drop      = 1'b1;
          cmd.drop_slot = tgt_slot;
          cmd.drop_rank = tgt_rank;
          held_dec      = 1'b1;
          emit          = 1'b1;
          emit_kind     = KIND_CLOSED;
          emit_handle   = tgt_handle;
          if (idle_hit) begin
            stat_inc[4] = 1'b1;
            emit_reason = RSN_IDLE;
          end else begin
            stat_inc[5] = 1'b1;
            emit_reason = RSN_LIFETIME;
          end
        end
      end
      S_NEXT: begin
        if (phase == PH_REAP) begin
          if (rem == '0) begin
            emit      = 1'b1;
            emit_last = 1'b1;
          end else begin
            tgt_rank_next = IDX_W'(rem - 1'b1);
          end
        end else begin
          tgt_rank_next = '0;
        end
      end
      default: begin
      end
    endcase
  end

  assign go_scan = (state_next == S_SCAN) && (state != S_SCAN);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      phase         <= PH_KEY;
      total_cap     <= CNT_W'(16);
      per_key_cap   <= CNT_W'(4);
      idle_timeout  <= TMO_W'(30000);
      max_lifetime  <= TMO_W'(600000);
      held          <= '0;
      rem           <= '0;
      scan_cnt      <= '0;
      pend          <= 1'b0;
      result_strobe <= 1'b0;
      hit_count           <= '0;
      miss_count          <= '0;
      key_cap_evictions   <= '0;
      total_cap_evictions <= '0;
      timeout_evictions   <= '0;
      lifetime_evictions  <= '0;
    end else begin
      state         <= state_next;
      phase         <= phase_next;
      result_strobe <= emit;
      if (cfg_we) begin
        case (cfg_index)
          CFG_TOTAL_CAP:    total_cap    <= cfg_data[CNT_W-1:0];
          CFG_PER_KEY_CAP:  per_key_cap  <= cfg_data[CNT_W-1:0];
          CFG_IDLE_TIMEOUT: idle_timeout <= cfg_data;
          default:          max_lifetime <= cfg_data;
        endcase
      end
      if (held_clr) begin
        held <= '0;
      end else if (held_inc) begin
        held <= held + 1'b1;
      end else if (held_dec) begin
        held <= held - 1'b1;
      end
      if (state == S_IDLE) begin
        rem <= held;
      end else if (rem_dec) begin
        rem <= rem - 1'b1;
      end
      if (go_scan) begin
        scan_cnt <= '0;
      end else if (state == S_SCAN && scan_cnt != CNT_W'(TABLE_ENTRIES)) begin
        scan_cnt <= scan_cnt + 1'b1;
      end
      pend <= (state == S_SCAN) && (scan_cnt != CNT_W'(TABLE_ENTRIES));
      if (stat_inc[0]) hit_count           <= hit_count + 1'b1;
      if (stat_inc[1]) miss_count          <= miss_count + 1'b1;
      if (stat_inc[2]) key_cap_evictions   <= key_cap_evictions + 1'b1;
      if (stat_inc[3]) total_cap_evictions <= total_cap_evictions + 1'b1;
      if (stat_inc[4]) timeout_evictions   <= timeout_evictions + 1'b1;
      if (stat_inc[5]) lifetime_evictions  <= lifetime_evictions + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    pslot    <= scan_cnt[IDX_W-1:0];
    tgt_rank <= tgt_rank_next;
    if (emit) begin
      kind         <= emit_kind;
      out_handle   <= emit_handle;
      close_reason <= emit_reason;
      last         <= emit_last;
    end
    if (state == S_IDLE && start) begin
      req_key    <= origin_key;
      req_handle <= handle;
      req_now    <= now_ms;
    end
    if (state == S_TEST) begin
      diff <= req_now - tgt_stamp;
      gt   <= req_now > tgt_stamp;
    end
    if (go_scan) begin
      match_cnt  <= '0;
      kmax_found <= 1'b0;
      kmin_found <= 1'b0;
      tgt_found  <= 1'b0;
      free_found <= 1'b0;
    end else if (pend) begin
      if (rd.valid) begin
        if (rd.key == req_key) begin
          match_cnt <= match_cnt + 1'b1;
          if (!kmax_found || rd.rank > kmax_rank) begin
            kmax_found  <= 1'b1;
            kmax_slot   <= pslot;
            kmax_rank   <= rd.rank;
            kmax_handle <= rd.handle;
          end
          if (!kmin_found || rd.rank < kmin_rank) begin
            kmin_found  <= 1'b1;
            kmin_slot   <= pslot;
            kmin_rank   <= rd.rank;
            kmin_handle <= rd.handle;
          end
        end
        if (rd.rank == tgt_rank) begin
          tgt_found  <= 1'b1;
          tgt_slot   <= pslot;
          tgt_handle <= rd.handle;
          tgt_stamp  <= rd.stamp;
        end
      end else if (!free_found) begin
        free_found <= 1'b1;
        free_slot  <= pslot;
      end
    end
  end

endmodule

>>> hdl/klip_table.sv
// Entry table: valid bits, recency ranks and per-slot key, handle and stamp.
module klip_table
  import klip_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  tbl_cmd_t         cmd,
  input  logic [IDX_W-1:0] rd_idx,
  output entry_t           rd_data
);

  logic [TABLE_ENTRIES-1:0] valid;
  logic [IDX_W-1:0]         rank   [TABLE_ENTRIES];
  logic [31:0]              key    [TABLE_ENTRIES];
  logic [31:0]              handle [TABLE_ENTRIES];
  logic [TIME_BITS-1:0]     stamp  [TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.drop) begin
      valid[cmd.drop_slot] <= 1'b0;
    end else if (cmd.ins) begin
      valid[cmd.ins_slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (cmd.drop) begin
        if (valid[i] && rank[i] > cmd.drop_rank) begin
          rank[i] <= rank[i] - 1'b1;
        end
      end else if (cmd.ins) begin
        if (IDX_W'(i) == cmd.ins_slot) begin
          rank[i] <= '0;
        end else if (valid[i]) begin
          rank[i] <= rank[i] + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins && !cmd.drop) begin
      key[cmd.ins_slot]    <= cmd.key;
      handle[cmd.ins_slot] <= cmd.handle;
      stamp[cmd.ins_slot]  <= cmd.stamp;
    end
    rd_data.valid  <= valid[rd_idx];
    rd_data.key    <= key[rd_idx];
    rd_data.handle <= handle[rd_idx];
    rd_data.stamp  <= stamp[rd_idx];
    rd_data.rank   <= rank[rd_idx];
  end

endmodule
